[src/lavm_pkg.sv]
// ----------------------------------------------------------------------------
// Look-at view matrix package
// Shared types, codes and constants for the look-at view matrix block.
// ----------------------------------------------------------------------------
package lavm_pkg;

   // default fraction bits of the unit axis components
   localparam int AXIS_FRAC_BITS_DEF = 30;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // normalization window and coarse scaling thresholds
   localparam logic [63:0] NORM_HI   = 64'h0000_0000_4000_0000;
   localparam logic [63:0] NORM_LO   = 64'h0000_0000_2000_0000;
   localparam logic [63:0] COARSE_HI = 64'h0000_0004_0000_0000;
   localparam logic [63:0] COARSE_LO = 64'h0000_0000_0200_0000;

   // row codes
   localparam logic [1:0] ROW_RIGHT = 2'd0;
   localparam logic [1:0] ROW_UP    = 2'd1;
   localparam logic [1:0] ROW_DIR   = 2'd2;

   // last step of a cross product sequence and of a dot product sequence
   localparam logic [2:0] CROSS_LAST_STEP = 3'd6;
   localparam logic [2:0] DOT_LAST_STEP   = 3'd3;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic signed [31:0] target_z;
      logic signed [31:0] up_x;
      logic signed [31:0] up_y;
      logic signed [31:0] up_z;
   } lavm_req_type;

   typedef struct packed {
      logic        [1:0]  row_index;
      logic signed [31:0] axis_x;
      logic signed [31:0] axis_y;
      logic signed [31:0] axis_z;
      logic signed [31:0] translation;
      logic               degenerate;
      logic               last_row;
   } lavm_rsp_type;

   // queued word: position, up vector and view difference (index 0 is x)
   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][31:0] up;
      logic [2:0][32:0] diff;
   } lavm_item_type;

   typedef struct packed {
      logic          valid;
      lavm_item_type item;
   } lavm_qhead_type;

   typedef struct packed {
      logic             start;
      logic [2:0][63:0] vec;
   } lavm_norm_req_type;

   typedef struct packed {
      logic             done;
      logic             degen;
      logic [2:0][31:0] axis;
   } lavm_norm_res_type;

   typedef enum logic [2:0] {
      NS_IDLE,
      NS_SCALE,
      NS_SQUARE,
      NS_ROOT,
      NS_DIVSET,
      NS_DIVIDE,
      NS_DONE
   } lavm_norm_state_type;

   typedef enum logic [3:0] {
      BS_IDLE,
      BS_SDIR,
      BS_NDIR,
      BS_CROSS1,
      BS_SRIGHT,
      BS_NRIGHT,
      BS_CROSS2,
      BS_SUP,
      BS_NUP,
      BS_DOT,
      BS_EMIT
   } lavm_back_state_type;

   // left operand index of each cross product step
   function automatic logic [1:0] cross_a_idx(input logic [2:0] step);
      logic [1:0] idx;
      unique case (step)
         3'd0: idx = 2'd1;
         3'd1: idx = 2'd2;
         3'd2: idx = 2'd2;
         3'd3: idx = 2'd0;
         3'd4: idx = 2'd0;
         3'd5: idx = 2'd1;
         default: idx = 2'd0;
      endcase
      return idx;
   endfunction

   // right operand index of each cross product step
   function automatic logic [1:0] cross_b_idx(input logic [2:0] step);
      logic [1:0] idx;
      unique case (step)
         3'd0: idx = 2'd2;
         3'd1: idx = 2'd1;
         3'd2: idx = 2'd0;
         3'd3: idx = 2'd2;
         3'd4: idx = 2'd1;
         3'd5: idx = 2'd0;
         default: idx = 2'd0;
      endcase
      return idx;
   endfunction

endpackage

[src/lavm_front.sv]
// ----------------------------------------------------------------------------
// Look-at view matrix front end
// Accepts request words, forms the view difference and queues them.
// ----------------------------------------------------------------------------
module lavm_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lavm_pkg::lavm_req_type req_data,
   output lavm_pkg::lavm_qhead_type qhead,
   input  logic                   q_pop
);
   import lavm_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   lavm_item_type entry_ff [QUEUE_DEPTH];
   lavm_item_type item_new;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;

   assign req_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;

   // form the view difference pos - target at full width
   always_comb begin
      item_new.pos     = {req_data.pos_z, req_data.pos_y, req_data.pos_x};
      item_new.up      = {req_data.up_z, req_data.up_y, req_data.up_x};
      item_new.diff[0] = {req_data.pos_x[31], req_data.pos_x}
                       - {req_data.target_x[31], req_data.target_x};
      item_new.diff[1] = {req_data.pos_y[31], req_data.pos_y}
                       - {req_data.target_y[31], req_data.target_y};
      item_new.diff[2] = {req_data.pos_z[31], req_data.pos_z}
                       - {req_data.target_z[31], req_data.target_z};
   end

   // advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // hold queued words
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_new;
      end
   end

   assign qhead.valid = (count_ff != '0);
   assign qhead.item  = entry_ff[rd_ptr_ff];

endmodule

[src/lavm_norm.sv]
// ----------------------------------------------------------------------------
// Look-at view matrix normalizer
// Scales a vector into range, takes the integer root of its squared length
// and divides each component by it, one step per cycle.
// ----------------------------------------------------------------------------
module lavm_norm #(
   parameter int AXIS_FRAC_BITS = lavm_pkg::AXIS_FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lavm_pkg::lavm_norm_req_type norm_req,
   output lavm_pkg::lavm_norm_res_type norm_res
);
   import lavm_pkg::*;

   localparam int QW    = AXIS_FRAC_BITS + 1;
   localparam int NW    = AXIS_FRAC_BITS + 31;
   localparam int CNT_W = 5;

   lavm_norm_state_type state_ff, state_in;
   logic [2:0][63:0]    mag_ff, mag_in;
   logic [2:0]          neg_ff, neg_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [59:0]         sq_ff, sq_in;
   logic [63:0]         sum_ff, sum_in;
   logic [63:0]         rn_ff, rn_in;
   logic [63:0]         root_ff, root_in;
   logic [30:0]         len_ff, len_in;
   logic [2:0][30:0]    rem_ff, rem_in;
   logic [2:0][QW-1:0]  lowsh_ff, lowsh_in;
   logic                degen_ff, degen_in;

   logic [63:0]      mx;
   logic [63:0]      bitv;
   logic [63:0]      trial;
   logic [2:0][63:0] num;
   logic [2:0][31:0] dtrial;
   logic [2:0][31:0] qval;

   // largest magnitude
   always_comb begin
      mx = mag_ff[0];
      if (mag_ff[1] > mx) begin
         mx = mag_ff[1];
      end
      if (mag_ff[2] > mx) begin
         mx = mag_ff[2];
      end
   end

   // next state and datapath
   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      sq_in    = sq_ff;
      sum_in   = sum_ff;
      rn_in    = rn_ff;
      root_in  = root_ff;
      len_in   = len_ff;
      rem_in   = rem_ff;
      lowsh_in = lowsh_ff;
      degen_in = degen_ff;
      bitv     = 64'd1 << {cnt_ff, 1'b0};
      trial    = root_ff + bitv;
      for (int i = 0; i < 3; i++) begin
         num[i]    = (mag_ff[i] << AXIS_FRAC_BITS) + 64'(root_ff[30:1]);
         dtrial[i] = {rem_ff[i], lowsh_ff[i][QW-1]};
      end
      unique case (state_ff)
         NS_IDLE: begin
            if (norm_req.start) begin
               for (int i = 0; i < 3; i++) begin
                  neg_in[i] = norm_req.vec[i][63];
                  mag_in[i] = norm_req.vec[i][63] ? 64'd0 - norm_req.vec[i]
                                                  : norm_req.vec[i];
               end
               if (norm_req.vec == '0) begin
                  degen_in = 1'b1;
                  state_in = NS_DONE;
               end else begin
                  degen_in = 1'b0;
                  state_in = NS_SCALE;
               end
            end
         end
         NS_SCALE: begin
            // bring the largest magnitude into the window
            priority if (mx >= COARSE_HI) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] >> 4;
            end else if (mx >= NORM_HI) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] >> 1;
            end else if (mx < COARSE_LO) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] << 4;
            end else if (mx < NORM_LO) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] << 1;
            end else begin
               cnt_in   = '0;
               sum_in   = '0;
               state_in = NS_SQUARE;
            end
         end
         NS_SQUARE: begin
            // square one component a cycle, accumulate the previous one
            if (cnt_ff < CNT_W'(3)) begin
               sq_in = mag_ff[cnt_ff[1:0]][29:0] * mag_ff[cnt_ff[1:0]][29:0];
            end
            if (cnt_ff != '0) begin
               sum_in = sum_ff + 64'(sq_ff);
            end
            if (cnt_ff == CNT_W'(3)) begin
               rn_in    = sum_ff + 64'(sq_ff);
               root_in  = '0;
               cnt_in   = CNT_W'(31);
               state_in = NS_ROOT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         NS_ROOT: begin
            // one root digit a cycle
            if (rn_ff >= trial) begin
               rn_in   = rn_ff - trial;
               root_in = (root_ff >> 1) + bitv;
            end else begin
               root_in = root_ff >> 1;
            end
            if (cnt_ff == '0) begin
               state_in = NS_DIVSET;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         NS_DIVSET: begin
            // load rounded dividends
            len_in = root_ff[30:0];
            for (int i = 0; i < 3; i++) begin
               rem_in[i]   = 31'(num[i][NW-1:QW]);
               lowsh_in[i] = num[i][QW-1:0];
            end
            cnt_in   = CNT_W'(QW - 1);
            state_in = NS_DIVIDE;
         end
         NS_DIVIDE: begin
            // one quotient bit a cycle in each lane
            for (int i = 0; i < 3; i++) begin
               if (dtrial[i] >= {1'b0, len_ff}) begin
                  rem_in[i]   = 31'(dtrial[i] - {1'b0, len_ff});
                  lowsh_in[i] = {lowsh_ff[i][QW-2:0], 1'b1};
               end else begin
                  rem_in[i]   = dtrial[i][30:0];
                  lowsh_in[i] = {lowsh_ff[i][QW-2:0], 1'b0};
               end
            end
            if (cnt_ff == '0) begin
               state_in = NS_DONE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         NS_DONE: begin
            state_in = NS_IDLE;
         end
         default: begin
            state_in = NS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= NS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      cnt_ff   <= cnt_in;
      sq_ff    <= sq_in;
      sum_ff   <= sum_in;
      rn_ff    <= rn_in;
      root_ff  <= root_in;
      len_ff   <= len_in;
      rem_ff   <= rem_in;
      lowsh_ff <= lowsh_in;
      degen_ff <= degen_in;
   end

   // restore signs, zero a degenerate vector
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qval[i]          = 32'(lowsh_ff[i]);
         norm_res.axis[i] = degen_ff ? 32'd0 : (neg_ff[i] ? 32'd0 - qval[i] : qval[i]);
      end
      norm_res.done  = (state_ff == NS_DONE);
      norm_res.degen = degen_ff;
   end

endmodule

[src/lavm_back.sv]
// ----------------------------------------------------------------------------
// Look-at view matrix back end
// Sequences normalizations, cross and dot products, and emits three rows.
// ----------------------------------------------------------------------------
module lavm_back #(
   parameter int AXIS_FRAC_BITS = lavm_pkg::AXIS_FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lavm_pkg::lavm_qhead_type    qhead,
   output logic                        q_pop,
   output lavm_pkg::lavm_norm_req_type norm_req,
   input  lavm_pkg::lavm_norm_res_type norm_res,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output lavm_pkg::lavm_rsp_type      rsp_data
);
   import lavm_pkg::*;

   localparam logic [63:0] RND = 64'd1 << (AXIS_FRAC_BITS - 1);

   lavm_back_state_type state_ff, state_in;
   logic [2:0][31:0] pos_ff, pos_in;
   logic [2:0][31:0] up_ff, up_in;
   logic [2:0][32:0] diff_ff, diff_in;
   logic [2:0][31:0] dir_ff, dir_in;
   logic [2:0][31:0] right_ff, right_in;
   logic [2:0][31:0] upax_ff, upax_in;
   logic [2:0]       dg_ff, dg_in;
   logic [2:0][63:0] cr_ff, cr_in;
   logic [63:0]      prod_ff;
   logic [63:0]      dot_ff, dot_in;
   logic [2:0]       step_ff, step_in;
   logic [1:0]       row_ff, row_in;
   lavm_rsp_type     rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic signed [31:0] mac_a, mac_b;
   logic signed [63:0] prod_in;
   logic [1:0]         sel_a, sel_b, sel_d;
   logic [2:0]         sm1;
   logic [2:0][31:0]   row_axis;
   logic               out_free;
   logic               dneg, tneg;
   logic [63:0]        dmag, rq;
   logic [31:0]        trans;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign sel_a    = cross_a_idx(step_ff);
   assign sel_b    = cross_b_idx(step_ff);
   assign sel_d    = (step_ff < DOT_LAST_STEP) ? step_ff[1:0] : 2'd0;
   assign sm1      = step_ff - 1'b1;

   // axis of the current row
   always_comb begin
      unique case (row_ff)
         ROW_RIGHT: row_axis = right_ff;
         ROW_UP:    row_axis = upax_ff;
         default:   row_axis = dir_ff;
      endcase
   end

   // select multiplier operands
   always_comb begin
      unique case (state_ff)
         BS_CROSS1: begin
            mac_a = up_ff[sel_a];
            mac_b = dir_ff[sel_b];
         end
         BS_CROSS2: begin
            mac_a = dir_ff[sel_a];
            mac_b = right_ff[sel_b];
         end
         BS_DOT: begin
            mac_a = row_axis[sel_d];
            mac_b = pos_ff[sel_d];
         end
         default: begin
            mac_a = '0;
            mac_b = '0;
         end
      endcase
      prod_in = mac_a * mac_b;
   end

   // negate, round and saturate the dot product
   always_comb begin
      dneg = dot_ff[63];
      dmag = dneg ? 64'd0 - dot_ff : dot_ff;
      tneg = !dneg && (dot_ff != '0);
      rq   = (dmag + RND) >> AXIS_FRAC_BITS;
      if (tneg) begin
         trans = (rq >= 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - rq);
      end else begin
         trans = (rq > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : rq[31:0];
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      up_in        = up_ff;
      diff_in      = diff_ff;
      dir_in       = dir_ff;
      right_in     = right_ff;
      upax_in      = upax_ff;
      dg_in        = dg_ff;
      cr_in        = cr_ff;
      dot_in       = dot_ff;
      step_in      = step_ff;
      row_in       = row_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      q_pop        = 1'b0;
      norm_req.start = 1'b0;
      norm_req.vec   = cr_ff;
      unique case (state_ff)
         BS_IDLE: begin
            if (qhead.valid) begin
               pos_in   = qhead.item.pos;
               up_in    = qhead.item.up;
               diff_in  = qhead.item.diff;
               q_pop    = 1'b1;
               state_in = BS_SDIR;
            end
         end
         BS_SDIR: begin
            norm_req.start = 1'b1;
            for (int i = 0; i < 3; i++) begin
               norm_req.vec[i] = {{31{diff_ff[i][32]}}, diff_ff[i]};
            end
            state_in = BS_NDIR;
         end
         BS_NDIR: begin
            if (norm_res.done) begin
               dir_in        = norm_res.axis;
               dg_in[ROW_DIR] = norm_res.degen;
               step_in       = '0;
               state_in      = BS_CROSS1;
            end
         end
         BS_CROSS1, BS_CROSS2: begin
            // even products start a term, odd products subtract from it
            if (step_ff != '0) begin
               if (!sm1[0]) begin
                  cr_in[sm1[2:1]] = prod_ff;
               end else begin
                  cr_in[sm1[2:1]] = cr_ff[sm1[2:1]] - prod_ff;
               end
            end
            if (step_ff == CROSS_LAST_STEP) begin
               state_in = (state_ff == BS_CROSS1) ? BS_SRIGHT : BS_SUP;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         BS_SRIGHT: begin
            norm_req.start = 1'b1;
            state_in       = BS_NRIGHT;
         end
         BS_NRIGHT: begin
            if (norm_res.done) begin
               right_in         = norm_res.axis;
               dg_in[ROW_RIGHT] = norm_res.degen;
               step_in          = '0;
               state_in         = BS_CROSS2;
            end
         end
         BS_SUP: begin
            norm_req.start = 1'b1;
            state_in       = BS_NUP;
         end
         BS_NUP: begin
            if (norm_res.done) begin
               upax_in       = norm_res.axis;
               dg_in[ROW_UP] = norm_res.degen;
               step_in       = '0;
               row_in        = ROW_RIGHT;
               state_in      = BS_DOT;
            end
         end
         BS_DOT: begin
            if (step_ff != '0) begin
               dot_in = ((step_ff == 3'd1) ? 64'd0 : dot_ff) + prod_ff;
            end
            if (step_ff == DOT_LAST_STEP) begin
               state_in = BS_EMIT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         BS_EMIT: begin
            // load the output register once it is free
            if (out_free) begin
               rsp_in.row_index   = row_ff;
               rsp_in.axis_x      = row_axis[0];
               rsp_in.axis_y      = row_axis[1];
               rsp_in.axis_z      = row_axis[2];
               rsp_in.translation = trans;
               rsp_in.degenerate  = dg_ff[row_ff];
               rsp_in.last_row    = (row_ff == ROW_DIR);
               rsp_valid_in       = 1'b1;
               if (row_ff == ROW_DIR) begin
                  state_in = BS_IDLE;
               end else begin
                  row_in   = row_ff + 1'b1;
                  step_in  = '0;
                  state_in = BS_DOT;
               end
            end
         end
         default: begin
            state_in = BS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      up_ff    <= up_in;
      diff_ff  <= diff_in;
      dir_ff   <= dir_in;
      right_ff <= right_in;
      upax_ff  <= upax_in;
      dg_ff    <= dg_in;
      cr_ff    <= cr_in;
      prod_ff  <= prod_in;
      dot_ff   <= dot_in;
      step_ff  <= step_in;
      row_ff   <= row_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[src/look_at_view_matrix_top.sv]
// ----------------------------------------------------------------------------
// Look-at view matrix top level
// Per request word the back end normalizes the view difference, forms and
// normalizes the right and up axes, and emits three rows with their translations.
// A new request word enters the back end only after the last row of the previous
// one is loaded; all three normalizations share one iterative root and divide unit.
// A zero-length vector skips its root and divide; a stalled row holds the sequencer.
// Reset: synchronous, empties the queue and idles the sequencer.
// ----------------------------------------------------------------------------
module look_at_view_matrix_top #(
   parameter int AXIS_FRAC_BITS = lavm_pkg::AXIS_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lavm_pkg::lavm_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output lavm_pkg::lavm_rsp_type rsp_data
);
   import lavm_pkg::*;

   lavm_qhead_type    qhead;
   logic              q_pop;
   lavm_norm_req_type norm_req;
   lavm_norm_res_type norm_res;

   lavm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .qhead     (qhead),
      .q_pop     (q_pop)
   );

   lavm_norm #(
      .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
   ) u_norm (
      .clock    (clock),
      .reset    (reset),
      .norm_req (norm_req),
      .norm_res (norm_res)
   );

   lavm_back #(
      .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .qhead     (qhead),
      .q_pop     (q_pop),
      .norm_req  (norm_req),
      .norm_res  (norm_res),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
